// File: design/crcfa_pkg.sv
package crcfa_pkg;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_PAREN = 8'd40;

  localparam logic [1:0] ST_BUSY    = 2'd0;
  localparam logic [1:0] ST_OK      = 2'd1;
  localparam logic [1:0] ST_BAD_CRC = 2'd2;
  localparam logic [1:0] ST_SHORT   = 2'd3;

  localparam logic [1:0] CNT_SAT = 2'd3;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [1:0] status;
    logic       last_of_frame;
  } res_t;

  // one accepted byte's worth of results, res[0] goes out first
  typedef struct packed {
    logic [1:0]     cnt;
    res_t [2:0]     res;
  } cmd_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [7:0] esc(input logic [7:0] b);
    if (b == CH_LF || b == CH_CR || b == CH_PAREN) begin
      return b + 8'd1;
    end
    return b;
  endfunction

  function automatic res_t mk_res(input logic [7:0] b, input logic v,
                                  input logic [1:0] st, input logic last);
    res_t r;
    r.out_byte      = b;
    r.byte_valid    = v;
    r.status        = st;
    r.last_of_frame = last;
    return r;
  endfunction

endpackage

// File: design/crcfa_front.sv
module crcfa_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic              mode,
  input  logic [7:0]        data_byte,
  input  logic              frame_last,
  input  logic              q_full,
  output logic              q_push,
  output crcfa_pkg::cmd_t   cmd
);
  import crcfa_pkg::*;

  logic [15:0] crc_reg, crc_next;
  logic [7:0]  delay_first, delay_first_next;
  logic [7:0]  delay_second, delay_second_next;
  logic [1:0]  byte_count, byte_count_next;
  logic        terminated, terminated_next;
  logic        frame_mode, frame_mode_next;

  logic        accept;
  logic        fresh;
  logic        mode_eff;
  logic        is_cr;
  logic        have_old;
  logic [1:0]  bc_inc;
  logic [15:0] upd;
  logic [15:0] crc_t;
  logic [7:0]  ds_t;
  logic [7:0]  df_t;
  logic [1:0]  bc_t;
  logic        crc_match;
  res_t        chk_res;

  assign accept   = push && !q_full;
  assign fresh    = (byte_count == 2'd0) && !terminated;
  assign mode_eff = fresh ? mode : frame_mode;
  assign is_cr    = (data_byte == CH_CR);
  assign have_old = byte_count[1];
  assign bc_inc   = (byte_count == CNT_SAT) ? CNT_SAT : byte_count + 2'd1;
  assign upd      = crc_byte(crc_reg, mode_eff ? delay_second : data_byte);

  // check mode: state as it stands after this byte is shifted in
  assign crc_t = (!is_cr && have_old) ? upd : crc_reg;
  assign ds_t  = is_cr ? delay_second : delay_first;
  assign df_t  = is_cr ? delay_first : data_byte;
  assign bc_t  = is_cr ? byte_count : bc_inc;
  assign crc_match = (esc(crc_t[15:8]) == ds_t) && (esc(crc_t[7:0]) == df_t);

  always_comb begin
    if (bc_t != CNT_SAT) begin
      chk_res = mk_res(8'd0, 1'b0, ST_SHORT, 1'b1);
    end else if (!crc_match) begin
      chk_res = mk_res(8'd0, 1'b0, ST_BAD_CRC, 1'b1);
    end else if (is_cr) begin
      chk_res = mk_res(CH_CR, 1'b1, ST_OK, 1'b1);
    end else begin
      chk_res = mk_res(8'd0, 1'b0, ST_OK, 1'b1);
    end
  end

  always_comb begin
    crc_next          = crc_reg;
    delay_first_next  = delay_first;
    delay_second_next = delay_second;
    byte_count_next   = byte_count;
    terminated_next   = terminated;
    frame_mode_next   = frame_mode;
    cmd               = '0;
    if (accept) begin
      if (terminated) begin
        if (frame_last) begin
          terminated_next = 1'b0;
        end
      end else begin
        frame_mode_next = mode_eff;
        if (!mode_eff) begin
          if (is_cr) begin
            if (byte_count == 2'd0) begin
              cmd.cnt    = 2'd1;
              cmd.res[0] = mk_res(8'd0, 1'b0, ST_SHORT, 1'b1);
            end else begin
              cmd.cnt    = 2'd3;
              cmd.res[0] = mk_res(esc(crc_reg[15:8]), 1'b1, ST_BUSY, 1'b0);
              cmd.res[1] = mk_res(esc(crc_reg[7:0]), 1'b1, ST_BUSY, 1'b0);
              cmd.res[2] = mk_res(CH_CR, 1'b1, ST_OK, 1'b1);
            end
            crc_next          = '0;
            delay_first_next  = '0;
            delay_second_next = '0;
            byte_count_next   = '0;
            terminated_next   = !frame_last;
          end else begin
            cmd.res[0] = mk_res(data_byte, 1'b1, ST_BUSY, 1'b0);
            if (frame_last) begin
              cmd.cnt    = 2'd3;
              cmd.res[1] = mk_res(esc(upd[15:8]), 1'b1, ST_BUSY, 1'b0);
              cmd.res[2] = mk_res(esc(upd[7:0]), 1'b1, ST_OK, 1'b1);
              crc_next          = '0;
              delay_first_next  = '0;
              delay_second_next = '0;
              byte_count_next   = '0;
            end else begin
              cmd.cnt         = 2'd1;
              crc_next        = upd;
              byte_count_next = bc_inc;
            end
          end
        end else begin
          if (!is_cr && !frame_last) begin
            crc_next          = crc_t;
            delay_first_next  = df_t;
            delay_second_next = ds_t;
            byte_count_next   = bc_t;
            if (have_old) begin
              cmd.cnt    = 2'd1;
              cmd.res[0] = mk_res(delay_second, 1'b1, ST_BUSY, 1'b0);
            end
          end else begin
            if (!is_cr && have_old) begin
              cmd.cnt    = 2'd2;
              cmd.res[0] = mk_res(delay_second, 1'b1, ST_BUSY, 1'b0);
              cmd.res[1] = chk_res;
            end else begin
              cmd.cnt    = 2'd1;
              cmd.res[0] = chk_res;
            end
            crc_next          = '0;
            delay_first_next  = '0;
            delay_second_next = '0;
            byte_count_next   = '0;
            terminated_next   = is_cr && !frame_last;
          end
        end
      end
    end
  end

  assign q_push = accept && (cmd.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg      <= '0;
      delay_first  <= '0;
      delay_second <= '0;
      byte_count   <= '0;
      terminated   <= 1'b0;
      frame_mode   <= 1'b0;
    end else begin
      crc_reg      <= crc_next;
      delay_first  <= delay_first_next;
      delay_second <= delay_second_next;
      byte_count   <= byte_count_next;
      terminated   <= terminated_next;
      frame_mode   <= frame_mode_next;
    end
  end

endmodule

// File: design/crcfa_queue.sv
module crcfa_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  crcfa_pkg::cmd_t   wdata,
  input  logic              rd,
  output crcfa_pkg::cmd_t   rdata,
  output logic              full,
  output logic              empty
);
  import crcfa_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  cmd_t          mem [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full  = (count == FULL_CNT);
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == LAST_PTR) ? '0 : wptr + AW'(1);
      end
      if (do_rd) begin
        rptr <= (rptr == LAST_PTR) ? '0 : rptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// File: design/crcfa_back.sv
module crcfa_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  crcfa_pkg::cmd_t   q_data,
  output logic              q_pop,
  input  logic              pop,
  output logic              empty,
  output crcfa_pkg::res_t   res
);
  import crcfa_pkg::*;

  cmd_t       cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       last_idx;
  logic       take;
  logic       finish;

  assign last_idx = (idx == cur.cnt - 2'd1);
  assign take     = cur_valid && pop;
  assign finish   = take && last_idx;
  assign q_pop    = !q_empty && (!cur_valid || finish);
  assign empty    = !cur_valid;
  assign res      = cur.res[idx];

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (finish) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (take) begin
      idx <= idx + 2'd1;
    end
  end

endmodule

// File: design/crc16_frame_append_check.sv
// CRC-16 (poly 0x1021, init 0, MSB first) frame appender and checker. One byte
// is taken per clock while full is low; in append mode the CRC of that byte is
// folded in within the same cycle. Each byte turns into a small command (zero to
// three results); commands with at least one result are queued for the output
// side, which hands out one result per cycle while pop is high. A byte that
// yields one result therefore sustains one byte per clock while pop keeps up; a
// frame terminator yields up to three results; full is high while QUEUE_DEPTH
// commands are pending. Results pass the command queue and output register.
// Status: 0 in progress, 1 ok, 2 CRC mismatch, 3 too short or empty.
module crc16_frame_append_check #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic       mode,
  input  logic [7:0] data_byte,
  input  logic       frame_last,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic [1:0] status,
  output logic       last_of_frame
);
  import crcfa_pkg::*;

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  cmd_t f_cmd;
  cmd_t q_data;
  res_t res;

  crcfa_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .mode       (mode),
    .data_byte  (data_byte),
    .frame_last (frame_last),
    .q_full     (q_full),
    .q_push     (q_push),
    .cmd        (f_cmd)
  );

  crcfa_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_push),
    .wdata (f_cmd),
    .rd    (q_pop),
    .rdata (q_data),
    .full  (q_full),
    .empty (q_empty)
  );

  crcfa_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .res     (res)
  );

  assign full          = q_full;
  assign out_byte      = res.out_byte;
  assign byte_valid    = res.byte_valid;
  assign status        = res.status;
  assign last_of_frame = res.last_of_frame;

  a_cmd_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_push |-> f_cmd.cnt != 2'd0)
    else $error("empty command queued");

  a_last_has_status: assert property (@(posedge clk) disable iff (rst)
    (!empty && last_of_frame) |-> status != ST_BUSY)
    else $error("frame end without status");

  a_status_only_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !byte_valid) |-> (out_byte == 8'd0 && last_of_frame))
    else $error("status-only result malformed");

  a_queue_pop_ok: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("pop from empty command queue");

endmodule

// File: verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import crcfa_pkg::*;

  localparam int N_RANDOM    = 400;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;

  typedef struct {
    logic       mode;
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic       mode = 1'b0;
  logic [7:0] data_byte = 8'h00;
  logic       frame_last = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic [1:0] status;
  logic       last_of_frame;

  crc16_frame_append_check dut (.*);

  frame_byte_t tx_q[$];
  res_t        frame_results_q[$];

  // shadow frame state
  logic [15:0] crc_q    = 16'h0000;
  logic [7:0]  held_new = 8'h00;
  logic [7:0]  held_old = 8'h00;
  logic [1:0]  cnt      = 2'd0;
  logic        term     = 1'b0;
  logic        fmode    = 1'b0;

  int  errors    = 0;
  int  n_sent    = 0;
  int  n_recv    = 0;
  int  quiet     = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    repeat (8) r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    return r;
  endfunction

  function automatic logic [7:0] escape_byte(input logic [7:0] b);
    case (b)
      CH_LF, CH_CR, CH_PAREN: return b + 8'd1;
      default: return b;
    endcase
  endfunction

  task automatic note_result(input logic [7:0] b, input logic v, input logic [1:0] st,
                             input logic l);
    res_t r;
    r.out_byte      = b;
    r.byte_valid    = v;
    r.status        = st;
    r.last_of_frame = l;
    frame_results_q.push_back(r);
  endtask

  task automatic predict_byte(input frame_byte_t it);
    logic [7:0] hi, lo;
    if (term) begin
      if (it.last) term = 1'b0;
      return;
    end
    if (cnt == 2'd0) fmode = it.mode;
    if (!fmode) begin
      if (it.data == CH_CR) begin
        if (cnt == 2'd0) begin
          note_result(8'h00, 1'b0, ST_SHORT, 1'b1);
        end else begin
          note_result(escape_byte(crc_q[15:8]), 1'b1, ST_BUSY, 1'b0);
          note_result(escape_byte(crc_q[7:0]), 1'b1, ST_BUSY, 1'b0);
          note_result(CH_CR, 1'b1, ST_OK, 1'b1);
        end
      end else begin
        crc_q = crc_step(crc_q, it.data);
        if (cnt != CNT_SAT) cnt = cnt + 2'd1;
        note_result(it.data, 1'b1, ST_BUSY, 1'b0);
        if (!it.last) return;
        note_result(escape_byte(crc_q[15:8]), 1'b1, ST_BUSY, 1'b0);
        note_result(escape_byte(crc_q[7:0]), 1'b1, ST_OK, 1'b1);
      end
    end else begin
      if (it.data != CH_CR) begin
        if (cnt >= 2'd2) begin
          crc_q = crc_step(crc_q, held_old);
          note_result(held_old, 1'b1, ST_BUSY, 1'b0);
        end
        held_old = held_new;
        held_new = it.data;
        if (cnt != CNT_SAT) cnt = cnt + 2'd1;
        if (!it.last) return;
      end
      if (cnt != CNT_SAT) begin
        note_result(8'h00, 1'b0, ST_SHORT, 1'b1);
      end else begin
        hi = escape_byte(crc_q[15:8]);
        lo = escape_byte(crc_q[7:0]);
        if (hi != held_old || lo != held_new) note_result(8'h00, 1'b0, ST_BAD_CRC, 1'b1);
        else if (it.data == CH_CR) note_result(CH_CR, 1'b1, ST_OK, 1'b1);
        else note_result(8'h00, 1'b0, ST_OK, 1'b1);
      end
    end
    crc_q    = 16'h0000;
    held_new = 8'h00;
    held_old = 8'h00;
    cnt      = 2'd0;
    term     = (it.data == CH_CR) && !it.last;
  endtask

  task automatic add_item(input logic m, input logic [7:0] b, input logic l);
    frame_byte_t it;
    it.mode = m;
    it.data = b;
    it.last = l;
    tx_q.push_back(it);
  endtask

  // payload without CR, CRC appended in check mode, terminated by CR or by last
  task automatic add_frame(input logic m, input int len, input bit use_cr, input bit corrupt,
                           input int trail);
    logic [15:0] c;
    logic [7:0]  b;
    logic [7:0]  body[$];
    c = 16'h0000;
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      if (b == CH_CR) b = 8'h0e;
      body.push_back(b);
      c = crc_step(c, b);
    end
    if (m) begin
      body.push_back(escape_byte(c[15:8]));
      body.push_back(escape_byte(c[7:0]));
      if (corrupt)
        body[$urandom_range(0, body.size() - 1)] ^= 8'h01 << $urandom_range(0, 7);
    end
    if (body.size() == 0) use_cr = 1'b1;
    foreach (body[i]) add_item(m, body[i], !use_cr && (i == body.size() - 1));
    if (use_cr) begin
      add_item(m, CH_CR, trail == 0);
      for (int i = 0; i < trail; i++)
        add_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), i == trail - 1);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        predict_byte(tx_q[0]);
        tx_q.delete(0);
        n_sent++;
      end
      if (!(push && full)) begin
        if (tx_q.size() != 0 &&
            ((n_sent >= 200 && n_sent < 300) || $urandom_range(0, 99) >= 35)) begin
          push       <= 1'b1;
          mode       <= tx_q[0].mode;
          data_byte  <= tx_q[0].data;
          frame_last <= tx_q[0].last;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        n_recv++;
        if (frame_results_q.size() == 0) begin
          $display("%0t: unexpected result byte %02h valid %0b status %0d last %0b",
                   $time, out_byte, byte_valid, status, last_of_frame);
          errors++;
        end else begin
          want = frame_results_q.pop_front();
          if (out_byte !== want.out_byte) begin
            $display("%0t: out_byte expected %02h actual %02h", $time, want.out_byte, out_byte);
            errors++;
          end
          if (byte_valid !== want.byte_valid) begin
            $display("%0t: byte_valid expected %0b actual %0b", $time, want.byte_valid,
                     byte_valid);
            errors++;
          end
          if (status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
            errors++;
          end
          if (last_of_frame !== want.last_of_frame) begin
            $display("%0t: last_of_frame expected %0b actual %0b", $time, want.last_of_frame,
                     last_of_frame);
            errors++;
          end
        end
      end
      if (n_recv == 150 && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= (n_recv >= 250 && n_recv < 400) || $urandom_range(0, 99) >= 35;
      end
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int          esc_seed;
    int          target;
    int          len;
    logic [15:0] c;

    // append: extremes, CR at end
    add_item(1'b0, 8'h00, 1'b0);
    add_item(1'b0, 8'hff, 1'b0);
    add_item(1'b0, CH_CR, 1'b1);
    // append: empty payload
    add_item(1'b0, CH_CR, 1'b1);
    // append: last-marked byte
    add_item(1'b0, 8'h55, 1'b1);
    // append: bytes after CR dropped
    add_frame(1'b0, 2, 1'b1, 1'b0, 2);
    // check: ok at CR, ok at last, mismatch
    add_frame(1'b1, 3, 1'b1, 1'b0, 0);
    add_frame(1'b1, 2, 1'b0, 1'b0, 0);
    add_frame(1'b1, 2, 1'b1, 1'b1, 0);
    // check: too short at CR, at last, CR first
    add_item(1'b1, 8'h41, 1'b0);
    add_item(1'b1, 8'h42, 1'b0);
    add_item(1'b1, CH_CR, 1'b1);
    add_item(1'b1, 8'h41, 1'b1);
    add_item(1'b1, CH_CR, 1'b1);
    // CRC byte needing escape, both modes
    esc_seed = 0;
    for (int v = 0; v < 256; v++) begin
      c = crc_step(16'h0000, v[7:0]);
      if (v[7:0] != CH_CR &&
          (escape_byte(c[15:8]) != c[15:8] || escape_byte(c[7:0]) != c[7:0])) begin
        esc_seed = v;
        break;
      end
    end
    c = crc_step(16'h0000, esc_seed[7:0]);
    add_item(1'b0, esc_seed[7:0], 1'b1);
    add_item(1'b1, esc_seed[7:0], 1'b0);
    add_item(1'b1, escape_byte(c[15:8]), 1'b0);
    add_item(1'b1, escape_byte(c[7:0]), 1'b1);

    target = tx_q.size() + N_RANDOM;
    while (tx_q.size() < target) begin
      if ($urandom_range(0, 99) < 10) begin
        add_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                 $urandom_range(0, 3) == 0);
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 8);
        add_frame(1'($urandom_range(0, 1)), len, 1'($urandom_range(0, 1)),
                  $urandom_range(0, 4) == 0,
                  ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (tx_q.size() != 0) @(posedge clk);
    while (frame_results_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: crc16_frame_append_check.f
design/crcfa_pkg.sv
design/crcfa_front.sv
design/crcfa_queue.sv
design/crcfa_back.sv
design/crc16_frame_append_check.sv
verif/tb.sv
